### rtl/mshr_pkg.sv
`default_nettype none

package mshr_pkg;

	localparam int NUM_ENTRIES_DEF = 8;
	localparam int MAX_TARGETS_DEF = 4;

	localparam int ADDR_W = 32;
	localparam int ROB_W  = 6;
	localparam int REG_W  = 6;
	localparam int DATA_W = 32;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FILL  = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_ACK  = 1'b0,
		KIND_RESP = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACK,
		ST_FRD,
		ST_FOUT
	} state_t;

	// status of one tag scan, held until the next start
	typedef struct packed {
		logic done;
		logic hit;
		logic free;
	} scan_stat_t;

endpackage

`default_nettype wire

### rtl/mshr_if.sv
`default_nettype none

interface mshr_req_if;
	import mshr_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [ADDR_W-1:0] line_addr;
	logic [ROB_W-1:0]  rob_slot;
	logic [REG_W-1:0]  dest_reg;
	logic [DATA_W-1:0] fill_data;

	modport source (
		output valid, cmd, line_addr, rob_slot, dest_reg, fill_data,
		input  ready
	);

	modport sink (
		input  valid, cmd, line_addr, rob_slot, dest_reg, fill_data,
		output ready
	);
endinterface

interface mshr_rsp_if;
	import mshr_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic              accepted;
	logic              merged;
	logic [ROB_W-1:0]  resp_rob;
	logic [REG_W-1:0]  resp_reg;
	logic [DATA_W-1:0] resp_data;
	logic              last;

	modport source (
		output valid, kind, accepted, merged, resp_rob, resp_reg, resp_data, last,
		input  ready
	);

	modport sink (
		input  valid, kind, accepted, merged, resp_rob, resp_reg, resp_data, last,
		output ready
	);
endinterface

`default_nettype wire

### rtl/mshr_tag_scan.sv
`default_nettype none

module mshr_tag_scan #(
	parameter int NUM_ENTRIES = mshr_pkg::NUM_ENTRIES_DEF,
	parameter int EIDX_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [mshr_pkg::ADDR_W-1:0] blk,
	input  wire logic [NUM_ENTRIES-1:0]      valid_vec,
	input  wire logic                        wr_en,
	input  wire logic [EIDX_W-1:0]           wr_idx,
	input  wire logic [mshr_pkg::ADDR_W-1:0] wr_tag,
	output mshr_pkg::scan_stat_t             stat,
	output logic [EIDX_W-1:0]                hit_idx,
	output logic [EIDX_W-1:0]                free_idx
);
	import mshr_pkg::*;

	localparam logic [EIDX_W-1:0] LAST_IDX = EIDX_W'(NUM_ENTRIES - 1);

	logic [ADDR_W-1:0] tag_mem [NUM_ENTRIES];

	logic              issuing_q;
	logic [EIDX_W-1:0] ictr_q;
	logic              cmp_v_s1;
	logic              last_s1;
	logic              vld_s1;
	logic [EIDX_W-1:0] cidx_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic              done_q;
	logic              hit_q;
	logic              free_q;
	logic [EIDX_W-1:0] hit_idx_q;
	logic [EIDX_W-1:0] free_idx_q;
	logic              match;

	// tag store, one read per cycle while the scan walks the entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_idx] <= wr_tag;
		end
		if (issuing_q) begin
			tag_s1 <= tag_mem[ictr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (issuing_q) begin
			cidx_s1 <= ictr_q;
			vld_s1  <= valid_vec[ictr_q];
		end
	end

	// the shared comparator
	assign match = cmp_v_s1 && vld_s1 && (tag_s1 == blk);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q  <= 1'b0;
			ictr_q     <= '0;
			cmp_v_s1   <= 1'b0;
			last_s1    <= 1'b0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
		end else if (start) begin
			issuing_q <= 1'b1;
			ictr_q    <= '0;
			cmp_v_s1  <= 1'b0;
			last_s1   <= 1'b0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			cmp_v_s1 <= issuing_q;
			last_s1  <= issuing_q && (ictr_q == LAST_IDX);
			if (issuing_q) begin
				// lowest free entry is picked up as the scan goes by
				if (!valid_vec[ictr_q] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= ictr_q;
				end
				if (ictr_q == LAST_IDX) begin
					issuing_q <= 1'b0;
				end else begin
					ictr_q <= ictr_q + EIDX_W'(1);
				end
			end
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cidx_s1;
			end
			if (cmp_v_s1 && last_s1) begin
				done_q <= 1'b1;
			end
		end
	end

	assign stat     = '{done: done_q, hit: hit_q, free: free_q};
	assign hit_idx  = hit_idx_q;
	assign free_idx = free_idx_q;

endmodule

`default_nettype wire

### rtl/mshr_tgt_ram.sv
`default_nettype none

module mshr_tgt_ram #(
	parameter int NUM_ENTRIES = mshr_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_TARGETS = mshr_pkg::MAX_TARGETS_DEF,
	parameter int EIDX_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
	parameter int TIDX_W      = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [EIDX_W+TIDX_W-1:0]    wr_addr,
	input  wire logic [mshr_pkg::ROB_W-1:0]  wr_rob,
	input  wire logic [mshr_pkg::REG_W-1:0]  wr_reg,
	input  wire logic                        rd_en,
	input  wire logic [EIDX_W+TIDX_W-1:0]    rd_addr,
	output logic [mshr_pkg::ROB_W-1:0]       rd_rob,
	output logic [mshr_pkg::REG_W-1:0]       rd_reg
);
	import mshr_pkg::*;

	// entry number in the upper address bits, target slot in the lower
	localparam int DEPTH = NUM_ENTRIES * (1 << TIDX_W);

	logic [ROB_W+REG_W-1:0] mem [DEPTH];
	logic [ROB_W+REG_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_rob, wr_reg};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_rob = rd_q[ROB_W+REG_W-1:REG_W];
	assign rd_reg = rd_q[REG_W-1:0];

endmodule

`default_nettype wire

### rtl/mshr_miss_table.sv
// allocate: tag scan from accept to acknowledgement, one tag
//   compared per cycle by a single comparator walking the tag memory
// fill: tag scan, then for each load response a target memory read and an
//   output register load, which waits while the output register is not free
// one word in flight at a time, no new request is taken until the last is done;
// the output register lets the next word in early
// reset clears valid bits, target counts, sequencer and output valid; tag and target
// memories are not cleared; invalid entries' tags are masked, targets read once written
`default_nettype none

module mshr_miss_table #(
	parameter int NUM_ENTRIES = mshr_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_TARGETS = mshr_pkg::MAX_TARGETS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mshr_req_if.sink   req,
	mshr_rsp_if.source rsp
);
	import mshr_pkg::*;

	localparam int EIDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int TIDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TARGETS);

	state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [ADDR_W-1:0] blk_q;
	logic [ROB_W-1:0]  rob_q;
	logic [REG_W-1:0]  reg_q;
	logic [DATA_W-1:0] data_q;

	logic [NUM_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       cnt_q [NUM_ENTRIES];
	logic [EIDX_W-1:0]      ent_q;
	logic [TIDX_W-1:0]      tk_q;
	logic                   ack_acc_q;
	logic                   ack_mrg_q;

	logic              out_v_q;
	kind_t             out_kind_q;
	logic              out_acc_q;
	logic              out_mrg_q;
	logic [ROB_W-1:0]  out_rob_q;
	logic [REG_W-1:0]  out_reg_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;

	scan_stat_t        stat;
	logic [EIDX_W-1:0] hit_idx;
	logic [EIDX_W-1:0] free_idx;

	logic              req_fire;
	logic              out_free;
	logic              hit_full;
	logic              fill_last;
	logic [ROB_W-1:0]  tgt_rob;
	logic [REG_W-1:0]  tgt_reg;

	// sequencer strobes
	logic                     scan_start;
	logic                     ent_alloc;
	logic                     ent_merge;
	logic                     ent_release;
	logic                     ack_set;
	logic                     ack_acc;
	logic                     ack_mrg;
	logic                     fill_begin;
	logic                     tk_step;
	logic                     tgt_wr;
	logic [EIDX_W+TIDX_W-1:0] tgt_wr_addr;
	logic                     tgt_rd;
	logic                     out_load;
	kind_t                    ol_kind;
	logic                     ol_acc;
	logic                     ol_mrg;
	logic [ROB_W-1:0]         ol_rob;
	logic [REG_W-1:0]         ol_reg;
	logic [DATA_W-1:0]        ol_data;
	logic                     ol_last;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_v_q || rsp.ready;
	assign hit_full  = (cnt_q[hit_idx] >= CNT_MAX);
	assign fill_last = ((CNT_W'(tk_q) + CNT_W'(1)) == cnt_q[ent_q]);

	mshr_tag_scan #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.EIDX_W      (EIDX_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.blk       (blk_q),
		.valid_vec (valid_q),
		.wr_en     (ent_alloc),
		.wr_idx    (free_idx),
		.wr_tag    (blk_q),
		.stat      (stat),
		.hit_idx   (hit_idx),
		.free_idx  (free_idx)
	);

	mshr_tgt_ram #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.MAX_TARGETS (MAX_TARGETS),
		.EIDX_W      (EIDX_W),
		.TIDX_W      (TIDX_W)
	) u_tgt (
		.clk     (clk),
		.wr_en   (tgt_wr),
		.wr_addr (tgt_wr_addr),
		.wr_rob  (rob_q),
		.wr_reg  (reg_q),
		.rd_en   (tgt_rd),
		.rd_addr ({ent_q, tk_q}),
		.rd_rob  (tgt_rob),
		.rd_reg  (tgt_reg)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.done) begin
					if (cmd_q == CMD_ALLOC) begin
						state_d = ST_ACK;
					end else if (stat.hit) begin
						state_d = ST_FRD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ACK: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FRD: begin
				state_d = ST_FOUT;
			end
			ST_FOUT: begin
				if (out_free) begin
					state_d = fill_last ? ST_IDLE : ST_FRD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		scan_start  = 1'b0;
		ent_alloc   = 1'b0;
		ent_merge   = 1'b0;
		ent_release = 1'b0;
		ack_set     = 1'b0;
		ack_acc     = 1'b0;
		ack_mrg     = 1'b0;
		fill_begin  = 1'b0;
		tk_step     = 1'b0;
		tgt_wr      = 1'b0;
		tgt_wr_addr = {free_idx, TIDX_W'(0)};
		tgt_rd      = 1'b0;
		out_load    = 1'b0;
		ol_kind     = KIND_ACK;
		ol_acc      = 1'b0;
		ol_mrg      = 1'b0;
		ol_rob      = '0;
		ol_reg      = '0;
		ol_data     = '0;
		ol_last     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				scan_start = req_fire;
			end
			ST_SCAN: begin
				if (stat.done) begin
					if (cmd_q == CMD_ALLOC) begin
						ack_set = 1'b1;
						if (stat.hit) begin
							// merge unless the target list is already full
							if (!hit_full) begin
								ent_merge   = 1'b1;
								tgt_wr      = 1'b1;
								tgt_wr_addr = {hit_idx, TIDX_W'(cnt_q[hit_idx])};
								ack_acc     = 1'b1;
								ack_mrg     = 1'b1;
							end
						end else if (stat.free) begin
							ent_alloc = 1'b1;
							tgt_wr    = 1'b1;
							ack_acc   = 1'b1;
						end
					end else begin
						fill_begin = stat.hit;
					end
				end
			end
			ST_ACK: begin
				out_load = out_free;
				ol_acc   = ack_acc_q;
				ol_mrg   = ack_mrg_q;
			end
			ST_FRD: begin
				tgt_rd = 1'b1;
			end
			ST_FOUT: begin
				out_load    = out_free;
				ol_kind     = KIND_RESP;
				ol_rob      = tgt_rob;
				ol_reg      = tgt_reg;
				ol_data     = data_q;
				ol_last     = fill_last;
				ent_release = out_free && fill_last;
				tk_step     = out_free && !fill_last;
			end
			default: begin
				scan_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request word, held for the whole operation
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q  <= cmd_t'(req.cmd);
			blk_q  <= req.line_addr;
			rob_q  <= req.rob_slot;
			reg_q  <= req.dest_reg;
			data_q <= req.fill_data;
		end
		if (ack_set) begin
			ack_acc_q <= ack_acc;
			ack_mrg_q <= ack_mrg;
		end
		if (fill_begin) begin
			ent_q <= hit_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			tk_q    <= '0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (ent_alloc) begin
				valid_q[free_idx] <= 1'b1;
				cnt_q[free_idx]   <= CNT_W'(1);
			end
			if (ent_merge) begin
				cnt_q[hit_idx] <= cnt_q[hit_idx] + CNT_W'(1);
			end
			if (ent_release) begin
				valid_q[ent_q] <= 1'b0;
				cnt_q[ent_q]   <= '0;
			end
			if (fill_begin) begin
				tk_q <= '0;
			end else if (tk_step) begin
				tk_q <= tk_q + TIDX_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= ol_kind;
			out_acc_q  <= ol_acc;
			out_mrg_q  <= ol_mrg;
			out_rob_q  <= ol_rob;
			out_reg_q  <= ol_reg;
			out_data_q <= ol_data;
			out_last_q <= ol_last;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.kind      = out_kind_q;
	assign rsp.accepted  = out_acc_q;
	assign rsp.merged    = out_mrg_q;
	assign rsp.resp_rob  = out_rob_q;
	assign rsp.resp_reg  = out_reg_q;
	assign rsp.resp_data = out_data_q;
	assign rsp.last      = out_last_q;

endmodule

`default_nettype wire
